// File: rtl/assert_macros.svh
// assertion macros for the rtl file that checks itself
// no dependencies; include with the bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge outside reset
`define OAID_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, checked at every rising edge outside reset
`define OAID_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: rtl/oaid_pkg.sv
// shared types and constants of the ordered array insert/delete block
// no dependencies
`default_nettype none

package oaid_pkg;

  localparam int DEPTH_DEF  = 16;
  localparam int DATA_W_DEF = 32;
  localparam int CNT_W_DEF  = $clog2(DEPTH_DEF + 1);
  localparam int OP_W       = 3;
  localparam int STATUS_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_DELETE = 3'd2,
    OP_GET    = 3'd3,
    OP_SET    = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GET_DATA,
    S_DEL_HEAD,
    S_MV_RD,
    S_MV_WR,
    S_INS_PUT,
    S_DONE
  } state_t;

  // sequencer status seen by the top level
  typedef struct packed {
    logic idle;
    logic move;
  } stat_t;

endpackage

`default_nettype wire

// File: rtl/oaid_ifs.sv
// valid/ready channel interfaces: command words in, response words out
// depends on oaid_pkg
`default_nettype none

interface oaid_cmd_if #(
  parameter int IDX_W  = oaid_pkg::CNT_W_DEF,
  parameter int DATA_W = oaid_pkg::DATA_W_DEF
);
  logic                       valid;
  logic                       ready;
  logic [oaid_pkg::OP_W-1:0]  op;
  logic [IDX_W-1:0]           index;
  logic signed [DATA_W-1:0]   value;

  modport source (output valid, output op, output index, output value, input ready);
  modport sink   (input valid, input op, input index, input value, output ready);
endinterface

interface oaid_rsp_if #(
  parameter int CNT_W  = oaid_pkg::CNT_W_DEF,
  parameter int DATA_W = oaid_pkg::DATA_W_DEF
);
  logic                          valid;
  logic                          ready;
  logic [oaid_pkg::STATUS_W-1:0] status;
  logic signed [DATA_W-1:0]      result_value;
  logic [CNT_W-1:0]              count;

  modport source (output valid, output status, output result_value, output count,
                  input ready);
  modport sink   (input valid, input status, input result_value, input count,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/oaid_ram.sv
// list storage: one write port, one read port, registered read data
// depends on oaid_pkg for default widths
`default_nettype none

module oaid_ram #(
  parameter int DEPTH  = oaid_pkg::DEPTH_DEF,
  parameter int DATA_W = oaid_pkg::DATA_W_DEF,
  parameter int AW     = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [AW-1:0]     raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/oaid_ctrl.sv
// sequencer: decodes a command word, walks the shift through the ram,
// holds the length and the response register; depends on oaid_pkg, oaid_ifs
`default_nettype none

module oaid_ctrl #(
  parameter int DEPTH  = oaid_pkg::DEPTH_DEF,
  parameter int DATA_W = oaid_pkg::DATA_W_DEF,
  parameter int CW     = $clog2(DEPTH + 1),
  parameter int AW     = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [CW-1:0]     capacity,
  oaid_cmd_if.sink               cmd,
  oaid_rsp_if.source             rsp,
  output logic                   ram_we,
  output logic      [AW-1:0]     ram_waddr,
  output logic      [DATA_W-1:0] ram_wdata,
  output logic                   ram_re,
  output logic      [AW-1:0]     ram_raddr,
  input  wire logic [DATA_W-1:0] ram_rdata,
  output oaid_pkg::stat_t        stat
);

  import oaid_pkg::*;

  localparam int CX = CW + 1;

  state_t            state, state_next;
  logic [CW-1:0]     count;
  logic [OP_W-1:0]   op_r;
  logic [CW-1:0]     idx_r;
  logic [DATA_W-1:0] val_r;
  logic [CW-1:0]     ptr;
  status_t           pend_status;
  logic [DATA_W-1:0] pend_value;
  logic              out_valid;
  status_t           out_status;
  logic [DATA_W-1:0] out_value;
  logic [CW-1:0]     out_count;

  logic              cmd_fire;
  logic [CW-1:0]     cap_lim;
  logic              full;
  logic              in_list;
  logic              idx_over;
  status_t           cmd_status;
  logic              is_ins;
  logic              head_more;
  logic              mv_more;
  logic              out_free;

  assign cmd.ready = (state == S_IDLE);
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign cap_lim   = (capacity > CW'(DEPTH)) ? CW'(DEPTH) : capacity;
  assign full      = (count >= cap_lim);
  assign in_list   = (cmd.index < count);
  assign idx_over  = (cmd.index > count);
  assign is_ins    = (op_r == OP_INSERT);
  assign head_more = ({1'b0, idx_r} + CX'(1)) < {1'b0, count};
  assign mv_more   = is_ins ? ({1'b0, ptr} > ({1'b0, idx_r} + CX'(1)))
                            : (({1'b0, ptr} + CX'(2)) < {1'b0, count});
  assign out_free  = !out_valid || rsp.ready;

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.result_value = out_value;
  assign rsp.count        = out_count;

  assign stat.idle = (state == S_IDLE);
  assign stat.move = (state == S_MV_RD) || (state == S_MV_WR);

  always_comb begin
    cmd_status = ST_OK;
    case (cmd.op)
      OP_APPEND: begin
        if (full) cmd_status = ST_FULL;
      end
      OP_INSERT: begin
        if (full) cmd_status = ST_FULL;
        else if (idx_over) cmd_status = ST_RANGE;
      end
      OP_DELETE, OP_GET, OP_SET: begin
        if (!in_list) cmd_status = ST_RANGE;
      end
      default: cmd_status = ST_OK;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd_fire) begin
          state_next = S_DONE;
          if (cmd_status == ST_OK) begin
            case (cmd.op)
              OP_INSERT: state_next = (count > cmd.index) ? S_MV_RD : S_INS_PUT;
              OP_DELETE: state_next = S_DEL_HEAD;
              OP_GET:    state_next = S_GET_DATA;
              default:   state_next = S_DONE;
            endcase
          end
        end
      end
      S_GET_DATA: state_next = S_DONE;
      S_DEL_HEAD: state_next = head_more ? S_MV_RD : S_DONE;
      S_MV_RD:    state_next = S_MV_WR;
      S_MV_WR: begin
        if (mv_more) state_next = S_MV_RD;
        else state_next = is_ins ? S_INS_PUT : S_DONE;
      end
      S_INS_PUT:  state_next = S_DONE;
      S_DONE:     state_next = out_free ? S_IDLE : S_DONE;
      default:    state_next = S_IDLE;
    endcase
  end

  // ram port drive
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    unique case (state)
      S_IDLE: begin
        if (cmd_fire && cmd_status == ST_OK) begin
          case (cmd.op)
            OP_APPEND: begin
              ram_we    = 1'b1;
              ram_waddr = count[AW-1:0];
              ram_wdata = cmd.value;
            end
            OP_SET: begin
              ram_we    = 1'b1;
              ram_waddr = cmd.index[AW-1:0];
              ram_wdata = cmd.value;
            end
            OP_DELETE, OP_GET: begin
              ram_re    = 1'b1;
              ram_raddr = cmd.index[AW-1:0];
            end
            default: ram_we = 1'b0;
          endcase
        end
      end
      S_MV_RD: begin
        ram_re    = 1'b1;
        ram_raddr = is_ins ? AW'(ptr - CW'(1)) : AW'(ptr + CW'(1));
      end
      S_MV_WR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr[AW-1:0];
        ram_wdata = ram_rdata;
      end
      S_INS_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[AW-1:0];
        ram_wdata = val_r;
      end
      S_GET_DATA, S_DEL_HEAD, S_DONE: ram_we = 1'b0;
      default: ram_we = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_fire && cmd_status == ST_OK && cmd.op == OP_APPEND) begin
            count <= count + CW'(1);
          end
        end
        S_DEL_HEAD: begin
          if (!head_more) count <= count - CW'(1);
        end
        S_MV_WR: begin
          if (!is_ins && !mv_more) count <= count - CW'(1);
        end
        S_INS_PUT: count <= count + CW'(1);
        default: count <= count;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (cmd_fire) begin
          op_r        <= cmd.op;
          idx_r       <= cmd.index;
          val_r       <= cmd.value;
          ptr         <= count;
          pend_status <= cmd_status;
          if (cmd_status != ST_OK) pend_value <= '1;
          else if (cmd.op == OP_SET) pend_value <= cmd.value;
          else pend_value <= '0;
        end
      end
      S_GET_DATA: pend_value <= ram_rdata;
      S_DEL_HEAD: begin
        pend_value <= ram_rdata;
        ptr        <= idx_r;
      end
      S_MV_WR: ptr <= is_ins ? ptr - CW'(1) : ptr + CW'(1);
      S_DONE: begin
        if (out_free) begin
          out_status <= pend_status;
          out_value  <= pend_value;
          out_count  <= count;
        end
      end
      default: ptr <= ptr;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/ordered_array_insert_delete_core.sv
// ordered word list with insert/delete by shifting: top level
// instantiates oaid_ctrl and oaid_ram; depends on oaid_pkg, oaid_ifs, assert_macros.svh
//
// usage
//   cmd: valid/ready channel, one command word per operation (op, index, value)
//   rsp: valid/ready channel, exactly one response word per command word
//        (status, result_value, count)
//   cfg_we/cfg_wdata: capacity register, write only while no command is in flight
// sequencer steps from command accept to response valid, in order
//   append, set, any error or unknown op: the final step only
//   get: a read data capture step, then the final step
//   insert at index i, length n: moves of the n - i entries from i on, put step, final step
//   delete at index i, length n: head step, moves of the n - i - 1 later entries, final step
//   each moved entry takes a ram read step and then a write step, since the ram
//   read data is registered; one command at a time
// the next command word is taken as soon as the sequencer is idle, even while
// the previous response word still waits in the output register
// a stalled receiver holds the response register; the sequencer then waits in
// its final step until the register frees, and takes no new command meanwhile
// reset clears length and control; the ram is not cleared (entries beyond the
// length are never read), so no clearing pass is needed; capacity resets to DEPTH
`default_nettype none

`include "assert_macros.svh"

module ordered_array_insert_delete_core #(
  parameter int DEPTH      = oaid_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = oaid_pkg::DATA_W_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [$clog2(DEPTH + 1)-1:0]      cfg_wdata,
  oaid_cmd_if.sink                               cmd,
  oaid_rsp_if.source                             rsp
);

  import oaid_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);

  // capacity register, clamped to DEPTH inside the sequencer
  logic [CW-1:0] capacity;

  // ram port between sequencer and storage
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CW'(DEPTH);
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  // sequencer: decode, shift walk, length and response register
  oaid_ctrl #(
    .DEPTH  (DEPTH),
    .DATA_W (DATA_WIDTH),
    .CW     (CW),
    .AW     (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .capacity  (capacity),
    .cmd       (cmd),
    .rsp       (rsp),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .stat      (stat)
  );

  // list storage; a move never reads the entry written in the same cycle
  oaid_ram #(
    .DEPTH  (DEPTH),
    .DATA_W (DATA_WIDTH),
    .AW     (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // reported length never exceeds the storage depth
  `OAID_ASSERT_IMP(a_count_bound, clk, rst, rsp.valid, rsp.count <= CW'(DEPTH))
  // an error response always carries all ones
  `OAID_ASSERT_IMP(a_err_value, clk, rst, rsp.valid && rsp.status != ST_OK,
                   rsp.result_value == '1)
  // an accepted command always leaves the sequencer busy in the following cycle
  `OAID_ASSERT_NXT(a_busy_after_accept, clk, rst, cmd.valid && cmd.ready, !stat.idle)
  // no command is taken while entries are being moved
  `OAID_ASSERT_IMP(a_no_accept_in_move, clk, rst, stat.move, !cmd.ready)

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// self-checking bench for the ordered list core: directed and random command words
// depends on oaid_pkg, oaid_ifs and ordered_array_insert_delete_core
`default_nettype none

module tb_top;
  import oaid_pkg::*;

  localparam int LIST_DEPTH  = DEPTH_DEF;
  localparam int HOLD_CYCLES = 300;        // long response back-pressure
  localparam int SETTLE_CYC  = 4;          // quiet cycles before a capacity write
  localparam int TAIL_CYC    = 40;         // quiet tail at the end of the run
  localparam int PHASE_WORDS = 120;
  localparam int NUM_PHASES  = 10;

  // op codes the core ignores
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

  // random op mix of a phase
  typedef enum int { MIX_BALANCED, MIX_GROW, MIX_SHRINK } op_mix_t;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [4:0]         index;
    logic signed [31:0] value;
    bit                 drain_first;  // hold this word until all responses are in
  } cmd_word_t;

  typedef struct {
    status_t            status;
    logic signed [31:0] value;
    logic [4:0]         count;
  } rsp_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [4:0] cfg_wdata = '0;

  oaid_cmd_if cmd_ch ();
  oaid_rsp_if rsp_ch ();

  ordered_array_insert_delete_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd_ch),
    .rsp       (rsp_ch)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // shared bench state
  // ---------------------------------------------------------------------------
  cmd_word_t cmd_backlog[$];   // command words not yet offered
  rsp_word_t pending_rsp[$];   // predicted responses, oldest first
  int        err_cnt = 0;
  bit        cmd_acc = 1'b0;   // command handshake at the last rising edge
  bit        idle_on = 1'b1;   // random gaps on both channels
  bit        hold_req = 1'b0;  // ask the receiver for one long hold-off
  int        send_gap = 0;
  int        stall_left = 0;
  int        hold_left = 0;

  // predictor copy of the list, its length and the capacity register
  logic signed [31:0] list_words [LIST_DEPTH];
  int                 list_len = 0;
  int                 cap_reg = LIST_DEPTH;

  // rough length seen by the stimulus generator, used only to aim indexes
  int gen_len = 0;
  int gen_cap = LIST_DEPTH;

  // ---------------------------------------------------------------------------
  // predictor: applies one command word to the list copy and returns the
  // response word the core must give for it
  // ---------------------------------------------------------------------------
  function automatic rsp_word_t list_op_result(logic [OP_W-1:0] op, logic [4:0] idx,
                                               logic signed [31:0] val);
    rsp_word_t r;
    int        lim;
    bit        full;
    bit        in_list;
    r.status = ST_OK;
    r.value  = '0;
    // a capacity past the array size acts as the array size
    lim     = (cap_reg > LIST_DEPTH) ? LIST_DEPTH : cap_reg;
    // capacity below the length also counts as full
    full    = (list_len >= lim);
    in_list = (int'(idx) < list_len);
    case (op)
      OP_APPEND: begin
        if (full) begin
          r.status = ST_FULL;
          r.value  = -1;
        end else begin
          list_words[list_len] = val;
          list_len++;
        end
      end
      OP_INSERT: begin
        // full is checked ahead of the index
        if (full) begin
          r.status = ST_FULL;
          r.value  = -1;
        end else if (int'(idx) > list_len) begin
          r.status = ST_RANGE;
          r.value  = -1;
        end else begin
          for (int i = list_len; i > int'(idx); i--) list_words[i] = list_words[i-1];
          list_words[idx] = val;
          list_len++;
        end
      end
      OP_DELETE: begin
        if (!in_list) begin
          r.status = ST_RANGE;
          r.value  = -1;
        end else begin
          r.value = list_words[idx];
          for (int i = int'(idx); i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
          list_words[list_len] = '0;
        end
      end
      OP_GET: begin
        if (!in_list) begin
          r.status = ST_RANGE;
          r.value  = -1;
        end else begin
          r.value = list_words[idx];
        end
      end
      OP_SET: begin
        if (!in_list) begin
          r.status = ST_RANGE;
          r.value  = -1;
        end else begin
          list_words[idx] = val;
          r.value = val;
        end
      end
      default: ;  // spare op codes leave everything alone
    endcase
    r.count = list_len[4:0];
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // word value with the extremes showing up often
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 19))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return -1;
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_word(logic [OP_W-1:0] op, logic [4:0] idx, logic signed [31:0] val,
                            bit drain = 1'b0);
    cmd_word_t w;
    int        lim;
    w.op          = op;
    w.index       = idx;
    w.value       = val;
    w.drain_first = drain;
    cmd_backlog.push_back(w);
    // keep the aiming length roughly in step with the core
    lim = (gen_cap > LIST_DEPTH) ? LIST_DEPTH : gen_cap;
    case (op)
      OP_APPEND: if (gen_len < lim) gen_len++;
      OP_INSERT: if (gen_len < lim && int'(idx) <= gen_len) gen_len++;
      OP_DELETE: if (int'(idx) < gen_len) gen_len--;
      default: ;
    endcase
  endtask

  // mostly well-formed words with in-range indexes, some out of range, a few spare ops
  task automatic queue_random(int n, op_mix_t mix);
    int               r;
    int               add_w;
    int               del_w;
    logic [OP_W-1:0]  op;
    logic [4:0]       idx;
    add_w = (mix == MIX_GROW) ? 60 : (mix == MIX_SHRINK) ? 22 : 40;
    del_w = (mix == MIX_GROW) ? 15 : (mix == MIX_SHRINK) ? 50 : 28;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < add_w / 2)              op = OP_APPEND;
      else if (r < add_w)             op = OP_INSERT;
      else if (r < add_w + del_w)     op = OP_DELETE;
      else if (r < 96 - (96 - add_w - del_w) / 2) op = OP_GET;
      else if (r < 96)                op = OP_SET;
      else                            op = OP_SPARE_A + 3'($urandom_range(0, 2));
      r = $urandom_range(0, 99);
      case (op)
        OP_INSERT: idx = (r < 8) ? 5'($urandom_range(gen_len + 1, 31))
                                 : 5'($urandom_range(0, gen_len));
        OP_DELETE, OP_GET, OP_SET:
          idx = (gen_len == 0 || r < 8) ? 5'($urandom_range(gen_len, 31))
                                        : 5'($urandom_range(0, gen_len - 1));
        default:   idx = 5'($urandom_range(0, 31));
      endcase
      // one word per phase waits for all responses to come in before going out
      queue_word(op, idx, pick_value(), k == n / 2);
    end
  endtask

  // wait for every word to be answered, then leave the core a few quiet cycles
  // checked at the rising edge, where backlog and valid are stable
  task automatic settle();
    do @(posedge clk);
    while (cmd_backlog.size() != 0 || pending_rsp.size() != 0 || cmd_ch.valid);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic write_capacity(logic [4:0] c);
    cfg_we    <= 1'b1;
    cfg_wdata <= c;
    cap_reg    = c;
    gen_cap    = c;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // command driver: launches words at the falling edge, holds until taken
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_cmd
    cmd_word_t w;
    logic      nv;
    nv = 1'b0;
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      cmd_ch.op    <= '0;
      cmd_ch.index <= '0;
      cmd_ch.value <= '0;
    end else begin
      if (cmd_ch.valid && !cmd_acc) begin
        nv = 1'b1;  // not taken yet, keep offering the same word
      end else if (send_gap > 0) begin
        send_gap--;
      end else if (cmd_backlog.size() != 0 &&
                   !(cmd_backlog[0].drain_first && pending_rsp.size() != 0)) begin
        w = cmd_backlog.pop_front();
        cmd_ch.op    <= w.op;
        cmd_ch.index <= w.index;
        cmd_ch.value <= w.value;
        nv = 1'b1;
        send_gap = idle_on ? draw_gap() : 0;
      end
      cmd_ch.valid <= nv;
    end
  end

  // ---------------------------------------------------------------------------
  // response ready: random stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_ready
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      rsp_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
      stall_left = idle_on ? draw_gap() : 0;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: check response words against the predictor, then predict for any
  // command word taken at this edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    rsp_word_t want;
    cmd_acc = 1'b0;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_rsp.size() == 0) begin
          $error("response word with none outstanding: status %0d value %0d count %0d",
                 rsp_ch.status, rsp_ch.result_value, rsp_ch.count);
          err_cnt++;
        end else begin
          want = pending_rsp.pop_front();
          if (rsp_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
            err_cnt++;
          end
          if (rsp_ch.result_value !== want.value) begin
            $error("result_value: expected %0d, got %0d", want.value, rsp_ch.result_value);
            err_cnt++;
          end
          if (rsp_ch.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, rsp_ch.count);
            err_cnt++;
          end
        end
      end
      if (cmd_ch.valid && cmd_ch.ready) begin
        cmd_acc = 1'b1;
        pending_rsp.push_back(list_op_result(cmd_ch.op, cmd_ch.index, cmd_ch.value));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin : run
    logic [4:0] caps  [NUM_PHASES];
    op_mix_t    mixes [NUM_PHASES];
    bit         quiet [NUM_PHASES];   // no gaps; long hold-off in these phases
    caps  = '{5'd31, 5'd16, 5'd4, 5'd16, 5'd1, 5'd20, 5'd0, 5'd9, 5'd2, 5'd16};
    mixes = '{MIX_GROW, MIX_BALANCED, MIX_BALANCED, MIX_SHRINK, MIX_BALANCED,
              MIX_GROW, MIX_BALANCED, MIX_BALANCED, MIX_GROW, MIX_SHRINK};
    quiet = '{0, 0, 1, 0, 0, 0, 0, 1, 0, 0};
    caps[7] = 5'($urandom_range(0, 31));

    for (int i = 0; i < LIST_DEPTH; i++) list_words[i] = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty list, boundaries of insert, shifting, spare ops
    // capacity is still at its reset value here
    queue_word(OP_GET,    5'd0,  '0);              // read of an empty list
    queue_word(OP_DELETE, 5'd0,  '0);              // delete from an empty list
    queue_word(OP_INSERT, 5'd1,  32'sd5);          // insert past the end
    queue_word(OP_INSERT, 5'd0,  32'sh7fff_ffff);  // insert at the length appends
    queue_word(OP_APPEND, 5'd31, 32'sh8000_0000);
    queue_word(OP_APPEND, 5'd0,  -1);
    queue_word(OP_INSERT, 5'd0,  '0);              // insert at the head shifts all
    queue_word(OP_INSERT, 5'd2,  32'sh5555_5555);
    queue_word(OP_GET,    5'd4,  '0);              // last entry
    queue_word(OP_GET,    5'd5,  '0);              // one past the last entry
    queue_word(OP_SET,    5'd1,  32'shaaaa_aaaa);
    queue_word(OP_DELETE, 5'd0,  '0);              // delete at the head
    queue_word(OP_DELETE, 5'd3,  '0);              // delete the tail
    queue_word(OP_DELETE, 5'd1,  '0);              // delete in the middle
    queue_word(OP_SPARE_A, 5'd31, -1);
    queue_word(OP_SPARE_B, 5'd16, 32'sh1234_5678);
    queue_word(OP_SPARE_C, 5'd0,  '0);
    queue_word(OP_GET,    5'd16, '0);

    // capacity below the current length: full, but entries stay usable
    settle();
    write_capacity(5'd1);
    queue_word(OP_APPEND, 5'd0,  32'sd7);
    queue_word(OP_INSERT, 5'd9,  32'sd8);          // full wins over a bad index
    queue_word(OP_SET,    5'd1,  32'sd9);
    queue_word(OP_DELETE, 5'd0,  '0);
    queue_word(OP_APPEND, 5'd0,  32'sd10);         // length equals capacity
    queue_word(OP_DELETE, 5'd0,  '0);
    queue_word(OP_APPEND, 5'd0,  32'sd11);
    queue_word(OP_APPEND, 5'd0,  32'sd12);

    // zero capacity: nothing can be added
    settle();
    write_capacity(5'd0);
    queue_word(OP_APPEND, 5'd0, 32'sd13);
    queue_word(OP_INSERT, 5'd0, 32'sd14);
    queue_word(OP_DELETE, 5'd0, '0);

    // random phases, each under its own capacity
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_capacity(caps[p]);
      idle_on = !quiet[p];
      // receiver goes quiet while the sender keeps offering, so the core backs up
      if (quiet[p]) hold_req = 1'b1;
      queue_random(PHASE_WORDS, mixes[p]);
    end

    settle();
    repeat (TAIL_CYC) @(negedge clk);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
